[hdl/checked_integer_divider_defines.svh]
// Assertion macros used by the checker file cid_checker.sv
`ifndef CHECKED_INTEGER_DIVIDER_DEFINES_SVH
`define CHECKED_INTEGER_DIVIDER_DEFINES_SVH

// Implication checked on every rising clock edge outside reset
`define CID_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked outside reset
`define CID_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/cid_pkg.sv]
// ----------------------------------------------------------------------------
// cid_pkg
// Types and constants for the checked integer divider.
// ----------------------------------------------------------------------------
`default_nettype none

package cid_pkg;

   localparam int unsigned DataW = 64;

   // Operand width codes
   localparam logic [1:0] WIDTH_8  = 2'd0;
   localparam logic [1:0] WIDTH_16 = 2'd1;
   localparam logic [1:0] WIDTH_32 = 2'd2;
   localparam logic [1:0] WIDTH_64 = 2'd3;

   typedef struct packed {
      logic [DataW-1:0] dividend;
      logic [DataW-1:0] divisor;
      logic [1:0]       width_code;
      logic             is_signed;
   } req_type;

   typedef struct packed {
      logic [DataW-1:0] quotient;
      logic [DataW-1:0] remainder;
      logic             div_error;
   } rsp_type;

   // Per-item control carried along the divider pipeline
   typedef struct packed {
      logic [DataW-1:0] mask;
      logic             q_neg;
      logic             r_neg;
      logic             err;
   } ctl_type;

   function automatic logic [DataW-1:0] width_mask(input logic [1:0] code);
      logic [DataW-1:0] m;
      unique case (code)
         WIDTH_8:  m = 64'h0000_0000_0000_00FF;
         WIDTH_16: m = 64'h0000_0000_0000_FFFF;
         WIDTH_32: m = 64'h0000_0000_FFFF_FFFF;
         default:  m = 64'hFFFF_FFFF_FFFF_FFFF;
      endcase
      return m;
   endfunction

endpackage

`default_nettype wire

[hdl/cid_prep.sv]
// ----------------------------------------------------------------------------
// cid_prep
// Input stage: masks operands, detects errors, takes magnitudes.
// ----------------------------------------------------------------------------
`default_nettype none

module cid_prep
   import cid_pkg::*;
(
   input  wire  logic             clock,
   input  wire  logic             reset,
   input  wire  logic             enable,
   input  wire  logic             in_valid,
   input  wire  req_type          in_data,
   output       logic             out_valid,
   output       logic [DataW-1:0] out_a,
   output       logic [DataW-1:0] out_b,
   output       ctl_type          out_ctl
);

   logic             valid_ff;
   logic [DataW-1:0] a_ff, b_ff, a_in, b_in;
   ctl_type          ctl_ff, ctl_in;

   // Operand conditioning
   always_comb begin
      logic [DataW-1:0] mask, sbit, a, b;
      logic             an, bn, ovf, zero;
      mask = width_mask(in_data.width_code);
      sbit = (mask >> 1) + 64'd1;
      a    = in_data.dividend & mask;
      b    = in_data.divisor & mask;
      an   = in_data.is_signed && ((a & sbit) != '0);
      bn   = in_data.is_signed && ((b & sbit) != '0);
      zero = (b == '0);
      ovf  = in_data.is_signed && (a == sbit) && (b == mask);
      a_in = an ? ((~a + 64'd1) & mask) : a;
      b_in = bn ? ((~b + 64'd1) & mask) : b;
      ctl_in.mask  = mask;
      ctl_in.q_neg = an ^ bn;
      ctl_in.r_neg = an;
      ctl_in.err   = zero || ovf;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         a_ff   <= a_in;
         b_ff   <= b_in;
         ctl_ff <= ctl_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_a     = a_ff;
   assign out_b     = b_ff;
   assign out_ctl   = ctl_ff;

endmodule

`default_nettype wire

[hdl/cid_stage.sv]
// ----------------------------------------------------------------------------
// cid_stage
// Restoring divider stage: BitsPerStage quotient bits per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cid_stage
   import cid_pkg::*;
#(
   parameter int unsigned BitsPerStage = 2
)
(
   input  wire  logic             clock,
   input  wire  logic             reset,
   input  wire  logic             enable,
   input  wire  logic             in_valid,
   input  wire  logic [DataW-1:0] in_q,
   input  wire  logic [DataW-1:0] in_r,
   input  wire  logic [DataW-1:0] in_b,
   input  wire  ctl_type          in_ctl,
   output       logic             out_valid,
   output       logic [DataW-1:0] out_q,
   output       logic [DataW-1:0] out_r,
   output       logic [DataW-1:0] out_b,
   output       ctl_type          out_ctl
);

   logic             valid_ff;
   logic [DataW-1:0] q_ff, r_ff, b_ff, q_in, r_in;
   ctl_type          ctl_ff;

   // Shift-subtract steps; q holds the remaining dividend bits at the top
   always_comb begin
      logic [DataW:0] rem, diff;
      q_in = in_q;
      r_in = in_r;
      for (int i = 0; i < int'(BitsPerStage); i++) begin
         rem  = {r_in, q_in[DataW-1]};
         diff = rem - {1'b0, in_b};
         q_in = {q_in[DataW-2:0], ~diff[DataW]};
         r_in = diff[DataW] ? rem[DataW-1:0] : diff[DataW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         q_ff   <= q_in;
         r_ff   <= r_in;
         b_ff   <= in_b;
         ctl_ff <= in_ctl;
      end
   end

   assign out_valid = valid_ff;
   assign out_q     = q_ff;
   assign out_r     = r_ff;
   assign out_b     = b_ff;
   assign out_ctl   = ctl_ff;

endmodule

`default_nettype wire

[hdl/cid_post.sv]
// ----------------------------------------------------------------------------
// cid_post
// Output stage: applies signs, masks to width, forces zero on error.
// ----------------------------------------------------------------------------
`default_nettype none

module cid_post
   import cid_pkg::*;
(
   input  wire  logic             clock,
   input  wire  logic             reset,
   input  wire  logic             enable,
   input  wire  logic             in_valid,
   input  wire  logic [DataW-1:0] in_q,
   input  wire  logic [DataW-1:0] in_r,
   input  wire  ctl_type          in_ctl,
   output       logic             out_valid,
   output       rsp_type          out_data
);

   logic    valid_ff;
   rsp_type data_ff, data_in;

   // Sign fix-up
   always_comb begin
      logic [DataW-1:0] q, r;
      q = in_ctl.q_neg ? (~in_q + 64'd1) : in_q;
      r = in_ctl.r_neg ? (~in_r + 64'd1) : in_r;
      data_in.quotient  = in_ctl.err ? '0 : (q & in_ctl.mask);
      data_in.remainder = in_ctl.err ? '0 : (r & in_ctl.mask);
      data_in.div_error = in_ctl.err;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

[hdl/checked_integer_divider.sv]
// Structure: a request passes through 2 + 64/BITS_PER_STAGE register stages before
// rsp_valid rises: the input stage, the divider stages and the output stage.
// Throughput: one transaction per cycle while not stalled; a chain of restoring
// shift-subtract stages, BITS_PER_STAGE quotient bits each, does the division.
// The whole pipeline holds when the output register is full and not taken.
// Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
// checked_integer_divider
// Pipelined signed/unsigned divider with quotient, remainder and error flag.
// ----------------------------------------------------------------------------
`default_nettype none

module checked_integer_divider
   import cid_pkg::*;
#(
   parameter int unsigned BITS_PER_STAGE = 2
)
(
   input  wire  logic    clock,
   input  wire  logic    reset,
   input  wire  logic    req_valid,
   output       logic    req_ready,
   input  wire  req_type req_data,
   output       logic    rsp_valid,
   input  wire  logic    rsp_ready,
   output       rsp_type rsp_data
);

   localparam int unsigned NumStages = DataW / BITS_PER_STAGE;

   logic enable;

   logic             v   [NumStages+1];
   logic [DataW-1:0] q   [NumStages+1];
   logic [DataW-1:0] r   [NumStages+1];
   logic [DataW-1:0] b   [NumStages+1];
   ctl_type          ctl [NumStages+1];

   // Global stall: advance when the output slot is free or being taken
   assign enable    = !rsp_valid || rsp_ready;
   assign req_ready = enable;

   cid_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_valid (v[0]),
      .out_a     (q[0]),
      .out_b     (b[0]),
      .out_ctl   (ctl[0])
   );

   assign r[0] = '0;

   for (genvar s = 0; s < int'(NumStages); s++) begin : g_stage
      cid_stage #(.BitsPerStage(BITS_PER_STAGE)) u_stage (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .in_valid  (v[s]),
         .in_q      (q[s]),
         .in_r      (r[s]),
         .in_b      (b[s]),
         .in_ctl    (ctl[s]),
         .out_valid (v[s+1]),
         .out_q     (q[s+1]),
         .out_r     (r[s+1]),
         .out_b     (b[s+1]),
         .out_ctl   (ctl[s+1])
      );
   end

   cid_post u_post (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (v[NumStages]),
      .in_q      (q[NumStages]),
      .in_r      (r[NumStages]),
      .in_ctl    (ctl[NumStages]),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

endmodule

`default_nettype wire

[hdl/cid_checker.sv]
// ----------------------------------------------------------------------------
// cid_checker
// Port-level checks on the divider, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "checked_integer_divider_defines.svh"

module cid_checker
   import cid_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   logic rsp_err, rsp_zero, rsp_free, rsp_stall, req_stall;

   // Handshake conditions
   assign rsp_err   = rsp_valid && rsp_data.div_error;
   assign rsp_zero  = (rsp_data.quotient == '0) && (rsp_data.remainder == '0);
   assign rsp_free  = !rsp_valid || rsp_ready;
   assign rsp_stall = rsp_valid && !rsp_ready;
   assign req_stall = req_valid && !req_ready;

   // Error results carry zero payload
   `CID_ASSERT_IMPL(a_err_zero, clock, reset, rsp_err, rsp_zero, "error result nonzero")

   // Input side is open whenever the output slot can move
   `CID_ASSERT_IMPL(a_ready, clock, reset, rsp_free, req_ready, "req_ready low, output free")

   // A stalled result holds
   `CID_ASSERT_NEXT(a_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_data), "rsp moved")

   // A waiting request holds
   `CID_ASSERT_NEXT(a_req_hold, clock, reset, req_stall, req_valid && $stable(req_data), "req moved")

endmodule

bind checked_integer_divider cid_checker u_cid_checker (.*);

`default_nettype wire

[bench/checked_integer_divider_test.sv]
// ----------------------------------------------------------------------------
// checked_integer_divider_test
// Self-checking bench for the pipelined checked divider. Operand pairs are
// sent at every width and in both modes, directed corners first and then
// random mixes. Each result is checked against a local quotient/remainder
// prediction, in order, while both sides idle at varying rates.
// ----------------------------------------------------------------------------
`default_nettype none

module checked_integer_divider_test;
   import cid_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned LatencyCycles = 40;
   localparam int unsigned WatchdogLimit = 20000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned fail_count = 0;
   int unsigned idle_cycles = 0;
   rsp_type     expected_results[$];

   checked_integer_divider u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Prediction of one division at the selected width
   function automatic rsp_type divide_predict(input req_type r);
      rsp_type          res;
      logic [DataW-1:0] mask, sign_bit, a, b, ma, mb, q, rem;
      logic             a_neg, b_neg;
      case (r.width_code)
         WIDTH_8:  mask = 64'hFF;
         WIDTH_16: mask = 64'hFFFF;
         WIDTH_32: mask = 64'hFFFF_FFFF;
         default:  mask = '1;
      endcase
      sign_bit = (mask >> 1) + 64'd1;
      a = r.dividend & mask;
      b = r.divisor & mask;
      res = '0;
      if (b == '0) begin
         res.div_error = 1'b1;
      end else if (r.is_signed && a == sign_bit && b == mask) begin
         res.div_error = 1'b1;
      end else if (r.is_signed) begin
         a_neg = (a & sign_bit) != '0;
         b_neg = (b & sign_bit) != '0;
         ma = a_neg ? ((-a) & mask) : a;
         mb = b_neg ? ((-b) & mask) : b;
         q = ma / mb;
         rem = ma % mb;
         if (a_neg != b_neg) q = -q;
         if (a_neg) rem = -rem;
         res.quotient = q & mask;
         res.remainder = rem & mask;
      end else begin
         res.quotient = a / b;
         res.remainder = a % b;
      end
      return res;
   endfunction

   // Send one transaction, recording its expected result at acceptance;
   // valid drops only while the sender idles
   task automatic send_division(input req_type r);
      while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      expected_results.push_back(divide_predict(r));
   endtask

   task automatic send_ops(input logic [63:0] a, input logic [63:0] b,
                           input logic [1:0] w, input logic s);
      req_type r;
      r.dividend = a;
      r.divisor = b;
      r.width_code = w;
      r.is_signed = s;
      send_division(r);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // Receiver stalls and result checking
   always @(posedge clock) begin
      rsp_type exp_res;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result transaction");
               fail_count++;
            end else begin
               exp_res = expected_results.pop_front();
               if (rsp_data.quotient !== exp_res.quotient) begin
                  $error("quotient: expected %h, got %h", exp_res.quotient,
                         rsp_data.quotient);
                  fail_count++;
               end
               if (rsp_data.remainder !== exp_res.remainder) begin
                  $error("remainder: expected %h, got %h", exp_res.remainder,
                         rsp_data.remainder);
                  fail_count++;
               end
               if (rsp_data.div_error !== exp_res.div_error) begin
                  $error("div_error: expected %b, got %b", exp_res.div_error,
                         rsp_data.div_error);
                  fail_count++;
               end
            end
         end
         rsp_ready <= (recv_idle_pct == 0) || ($urandom_range(99, 0) >= recv_idle_pct);
      end
   end

   // Watchdog on cycles with no accepted transaction
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else if (!reset) begin
         idle_cycles++;
         if (idle_cycles >= WatchdogLimit) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // Width extremes, both modes, zero divisor and signed overflow
   task automatic test_directed();
      logic [1:0]  w;
      logic [63:0] m, sb;
      for (int i = 0; i < 4; i++) begin
         w = i[1:0];
         m = (w == WIDTH_8) ? 64'hFF : (w == WIDTH_16) ? 64'hFFFF :
             (w == WIDTH_32) ? 64'hFFFF_FFFF : '1;
         sb = (m >> 1) + 64'd1;
         send_ops(m, 64'd0, w, 1'b0);
         send_ops(sb | ~m, m, w, 1'b1);
         send_ops(m, 64'd1, w, 1'b0);
         send_ops(sb, 64'd1, w, 1'b1);
         send_ops(~m | 64'd7, m, w, 1'b1);
         send_ops(64'd0, ~m, w, 1'b1);
      end
   endtask

   // Random mix, biased toward small divisors and corner operands
   task automatic test_random(input int unsigned count);
      logic [63:0] a, b;
      for (int unsigned n = 0; n < count; n++) begin
         a = rand64();
         b = rand64();
         case ($urandom_range(5, 0))
            0: b = b & 64'hF;
            1: b = '1;
            2: a = 64'h8000_0000_0000_0000 >> (8 * $urandom_range(7, 0));
            3: b = {60'd0, 4'($urandom_range(15, 0))} ^ {64{b[0]}};
            default: ;
         endcase
         send_ops(a, b, 2'($urandom_range(3, 0)), 1'($urandom_range(1, 0)));
      end
   endtask

   task automatic drain();
      while (expected_results.size() != 0) @(posedge clock);
      repeat (LatencyCycles) @(posedge clock);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      send_idle_pct = 30;
      recv_idle_pct = 80;
      test_random(150);
      send_idle_pct = 80;
      recv_idle_pct = 30;
      test_random(150);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(150);
      req_valid <= 1'b0;
      drain();
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

`default_nettype wire
